>>> sv/privileged_csr_emulation_unit_macros.svh
`ifndef PRIVILEGED_CSR_EMULATION_UNIT_MACROS_SVH
`define PRIVILEGED_CSR_EMULATION_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define PCSR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define PCSR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pcsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcsr_pkg;

    // Number of virtual CSRs and the width of an index into them.
    localparam int NUM_CSRS  = 39;
    localparam int CSR_IDX_W = (NUM_CSRS > 1) ? $clog2(NUM_CSRS) : 1;

    // Depth of the queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 144;

    // Privilege levels.
    localparam logic [1:0] LVL_U = 2'd0;
    localparam logic [1:0] LVL_S = 2'd1;
    localparam logic [1:0] LVL_M = 2'd2;

    // Operation classes produced by the front end.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_ECALL = 3'd2;
    localparam logic [OP_W-1:0] OP_SRET  = 3'd3;
    localparam logic [OP_W-1:0] OP_MRET  = 3'd4;
    localparam logic [OP_W-1:0] OP_NOP   = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD   = 3'd6;

    // funct3 codes.
    localparam logic [2:0] F3_SYSTEM = 3'd0;
    localparam logic [2:0] F3_CSRW   = 3'd1;
    localparam logic [2:0] F3_CSRR   = 3'd2;

    // System instruction addresses.
    localparam logic [11:0] ADDR_ECALL = 12'h000;
    localparam logic [11:0] ADDR_SRET  = 12'h102;
    localparam logic [11:0] ADDR_MRET  = 12'h302;

    // Slots of CSRs with special handling.
    localparam logic [CSR_IDX_W-1:0] IDX_SSTATUS   = CSR_IDX_W'(8);
    localparam logic [CSR_IDX_W-1:0] IDX_STVEC     = CSR_IDX_W'(12);
    localparam logic [CSR_IDX_W-1:0] IDX_MVENDORID = CSR_IDX_W'(15);
    localparam logic [CSR_IDX_W-1:0] IDX_MSTATUS   = CSR_IDX_W'(19);
    localparam logic [CSR_IDX_W-1:0] IDX_MEPC      = CSR_IDX_W'(28);
    localparam logic [CSR_IDX_W-1:0] IDX_SEPC      = CSR_IDX_W'(35);

    localparam logic [63:0] MVENDOR_RESET = 64'hC5E536;
    localparam logic [63:0] MSTATUS_RESET = 64'h1800;

    // CSR address and minimum privilege for each slot.
    localparam logic [11:0] CSR_ADDR_ROM [NUM_CSRS] = '{
        12'h000, 12'h004, 12'h005, 12'h040, 12'h041, 12'h042, 12'h043, 12'h044,
        12'h100, 12'h102, 12'h103, 12'h104, 12'h105, 12'h106, 12'h180,
        12'hF11, 12'hF12, 12'hF13, 12'hF14,
        12'h300, 12'h301, 12'h302, 12'h303, 12'h304, 12'h305, 12'h306, 12'h310,
        12'h340, 12'h341, 12'h342, 12'h343, 12'h344, 12'h34A, 12'h34B,
        12'h140, 12'h141, 12'h142, 12'h143, 12'h144
    };

    localparam logic [1:0] CSR_LEVEL_ROM [NUM_CSRS] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

    // One classified item, passed from front to back through the queue.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic                 found;
        logic [CSR_IDX_W-1:0] idx;
        logic [1:0]           min_level;
        logic [4:0]           rd;
        logic [63:0]          pc;
        logic [63:0]          src;
    } pcsr_item_t;

    // One result item.
    typedef struct packed {
        logic        killed;
        logic [63:0] next_pc;
        logic        write_back;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic [1:0]  privilege;
    } pcsr_result_t;

    // Value of a CSR slot that has never been written.
    function automatic logic [63:0] csr_reset_value(input logic [CSR_IDX_W-1:0] idx);
        logic [63:0] val;
        val = 64'd0;
        if (idx == IDX_MVENDORID)
        begin
            val = MVENDOR_RESET;
        end
        else if (idx == IDX_MSTATUS)
        begin
            val = MSTATUS_RESET;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

>>> sv/privileged_csr_emulation_unit.sv
// Privileged CSR emulation unit: emulates trapped csrw, csrr, ecall, sret and
// mret for a guest, keeping 39 virtual CSRs and the current privilege level.
// The slave channel (s_axis_*) carries one trapped instruction per beat with
// its pc and the value of the rs1 register. The master channel (m_axis_*)
// returns exactly one result beat per input beat, in order: kill flag, next
// pc, register write-back and the privilege after the step.
// Input beats enter a two-entry queue after being classified, so the input
// side keeps accepting while the back end works or while a result waits.
// The back end reads the CSR memory for an item in its idle state, then
// executes it and loads the output register in its execute state; it pops
// the next item from the queue only once the current one has executed.
// When the receiver stalls, the finished result holds in the output register,
// the back end holds its next item, and once the queue fills s_axis_tready
// drops. Reset (rst_n low, asynchronous) empties the queue and the output,
// puts the guest in machine mode and restores the CSR reset values, with
// mvendorid at 0xC5E536 and mstatus at 0x1800; all others read as zero.
`timescale 1ns / 1ps
`default_nettype none

module privileged_csr_emulation_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // Fields from bit 0 up: instruction (32), pc (64), source_value (64).
    input  wire logic [pcsr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // Fields from bit 0 up: killed (1), next_pc (64), write_back (1),
    // dest_index (5), dest_value (64), privilege (2), then zero fill (7).
    output logic [pcsr_pkg::OUT_TDATA_W-1:0]           m_axis_tdata
);

    pcsr_pkg::pcsr_item_t   front_item;
    pcsr_pkg::pcsr_item_t   head_item;
    pcsr_pkg::pcsr_result_t result;
    logic                   q_not_full;
    logic                   q_not_empty;
    logic                   q_pop;

    // Front end: decodes the instruction and looks up the CSR address.
    pcsr_front u_front (
        .instruction  (s_axis_tdata[31:0]),
        .pc           (s_axis_tdata[95:32]),
        .source_value (s_axis_tdata[159:96]),
        .item         (front_item)
    );

    assign s_axis_tready = q_not_full;

    pcsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head_item (head_item),
        .not_empty (q_not_empty)
    );

    // Back end: privilege checks, CSR state and the output register.
    pcsr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (q_not_empty),
        .head_pop   (q_pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (result)
    );

    assign m_axis_tdata = {7'd0, result.privilege, result.dest_value, result.dest_index,
                           result.write_back, result.next_pc, result.killed};

endmodule

`default_nettype wire

>>> sv/pcsr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcsr_front (
    input  wire logic [31:0]          instruction,
    input  wire logic [63:0]          pc,
    input  wire logic [63:0]          source_value,
    output pcsr_pkg::pcsr_item_t      item
);

    logic [2:0]                     funct3;
    logic [11:0]                    addr;
    logic                           hit;
    logic [pcsr_pkg::CSR_IDX_W-1:0] hit_idx;
    logic [1:0]                     hit_level;

    assign funct3 = instruction[14:12];
    assign addr   = instruction[31:20];

    // Address lookup against the ROM; the lowest matching slot wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        hit_level = pcsr_pkg::LVL_U;
        for (int i = pcsr_pkg::NUM_CSRS - 1; i >= 0; i--)
        begin
            if (addr == pcsr_pkg::CSR_ADDR_ROM[i])
            begin
                hit       = 1'b1;
                hit_idx   = pcsr_pkg::CSR_IDX_W'(i);
                hit_level = pcsr_pkg::CSR_LEVEL_ROM[i];
            end
        end
    end

    always_comb
    begin
        item.found     = 1'b0;
        item.idx       = '0;
        item.min_level = pcsr_pkg::LVL_U;
        item.rd        = instruction[11:7];
        item.pc        = pc;
        item.src       = source_value;
        case (funct3)
            pcsr_pkg::F3_CSRW:
            begin
                item.op        = pcsr_pkg::OP_WRITE;
                item.found     = hit;
                item.idx       = hit_idx;
                item.min_level = hit_level;
            end
            pcsr_pkg::F3_CSRR:
            begin
                item.op        = pcsr_pkg::OP_READ;
                item.found     = hit;
                item.idx       = hit_idx;
                item.min_level = hit_level;
            end
            pcsr_pkg::F3_SYSTEM:
            begin
                if (addr == pcsr_pkg::ADDR_ECALL)
                begin
                    item.op = pcsr_pkg::OP_ECALL;
                end
                else if (addr == pcsr_pkg::ADDR_SRET)
                begin
                    item.op = pcsr_pkg::OP_SRET;
                end
                else if (addr == pcsr_pkg::ADDR_MRET)
                begin
                    item.op = pcsr_pkg::OP_MRET;
                end
                else
                begin
                    item.op = pcsr_pkg::OP_NOP;
                end
            end
            default:
            begin
                item.op = pcsr_pkg::OP_BAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/pcsr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pcsr_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire pcsr_pkg::pcsr_item_t push_item,
    output logic                      not_full,
    input  wire logic                 pop,
    output pcsr_pkg::pcsr_item_t      head_item,
    output logic                      not_empty
);

    pcsr_pkg::pcsr_item_t             entry_reg [pcsr_pkg::QUEUE_DEPTH];
    logic [pcsr_pkg::QUEUE_PTR_W-1:0] wptr_reg;
    logic [pcsr_pkg::QUEUE_PTR_W-1:0] wptr_next;
    logic [pcsr_pkg::QUEUE_PTR_W-1:0] rptr_reg;
    logic [pcsr_pkg::QUEUE_PTR_W-1:0] rptr_next;
    logic [pcsr_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [pcsr_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                             do_push;
    logic                             do_pop;

    assign not_full  = (count_reg != pcsr_pkg::QUEUE_CNT_W'(pcsr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_item = entry_reg[rptr_reg];

    // Pointers wrap naturally since the depth is a power of two.
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/pcsr_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "privileged_csr_emulation_unit_macros.svh"

module pcsr_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pcsr_pkg::pcsr_item_t head_item,
    input  wire logic                 head_valid,
    output logic                      head_pop,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output pcsr_pkg::pcsr_result_t    res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                           state_reg;
    logic                           state_next;
    pcsr_pkg::pcsr_item_t           item_reg;

    // Slots other than the status, vector and epc registers live in memory.
    logic [63:0]                    csr_mem [pcsr_pkg::NUM_CSRS];
    logic [63:0]                    mem_rdata_reg;
    logic                           rd_valid_reg;
    logic [pcsr_pkg::NUM_CSRS-1:0]  valid_reg;
    logic [pcsr_pkg::NUM_CSRS-1:0]  valid_next;
    logic                           mem_we;

    logic [63:0]                    sstatus_reg;
    logic [63:0]                    sstatus_next;
    logic [63:0]                    stvec_reg;
    logic [63:0]                    stvec_next;
    logic [63:0]                    mstatus_reg;
    logic [63:0]                    mstatus_next;
    logic [63:0]                    mepc_reg;
    logic [63:0]                    mepc_next;
    logic [63:0]                    sepc_reg;
    logic [63:0]                    sepc_next;
    logic [1:0]                     current_level_reg;
    logic [1:0]                     current_level_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    pcsr_pkg::pcsr_result_t         res_reg;
    pcsr_pkg::pcsr_result_t         res_next;

    logic                           fire;
    logic                           special;
    logic                           lvl_ok;
    logic                           kill;
    logic                           csr_we;
    logic [63:0]                    csr_cur;
    logic [63:0]                    sret_status;
    logic [63:0]                    mret_status;
    logic [1:0]                     mret_level;

    assign head_pop  = (state_reg == ST_IDLE) && head_valid;
    assign fire      = (state_reg == ST_EXEC) && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    assign special = (item_reg.idx == pcsr_pkg::IDX_SSTATUS) ||
                     (item_reg.idx == pcsr_pkg::IDX_STVEC) ||
                     (item_reg.idx == pcsr_pkg::IDX_MSTATUS) ||
                     (item_reg.idx == pcsr_pkg::IDX_MEPC) ||
                     (item_reg.idx == pcsr_pkg::IDX_SEPC);
    assign lvl_ok  = (current_level_reg >= item_reg.min_level);

    // Current value of the addressed CSR.
    always_comb
    begin
        if (item_reg.idx == pcsr_pkg::IDX_SSTATUS)
        begin
            csr_cur = sstatus_reg;
        end
        else if (item_reg.idx == pcsr_pkg::IDX_STVEC)
        begin
            csr_cur = stvec_reg;
        end
        else if (item_reg.idx == pcsr_pkg::IDX_MSTATUS)
        begin
            csr_cur = mstatus_reg;
        end
        else if (item_reg.idx == pcsr_pkg::IDX_MEPC)
        begin
            csr_cur = mepc_reg;
        end
        else if (item_reg.idx == pcsr_pkg::IDX_SEPC)
        begin
            csr_cur = sepc_reg;
        end
        else if (rd_valid_reg)
        begin
            csr_cur = mem_rdata_reg;
        end
        else
        begin
            csr_cur = pcsr_pkg::csr_reset_value(item_reg.idx);
        end
    end

    // Status updates for the return instructions.
    always_comb
    begin
        sret_status       = sstatus_reg;
        sret_status[1]    = sstatus_reg[5];
        sret_status[5]    = 1'b1;
        sret_status[8]    = 1'b0;

        mret_level        = mstatus_reg[12] ? pcsr_pkg::LVL_M : mstatus_reg[12:11];
        mret_status       = mstatus_reg;
        mret_status[3]    = mstatus_reg[7];
        mret_status[7]    = 1'b1;
        mret_status[12:11] = 2'b00;
        if (mret_level != pcsr_pkg::LVL_M)
        begin
            mret_status[17] = 1'b0;
        end
    end

    // Execute one item: result and state updates.
    always_comb
    begin
        kill                = 1'b0;
        csr_we              = 1'b0;
        res_next.killed     = 1'b0;
        res_next.next_pc    = item_reg.pc;
        res_next.write_back = 1'b0;
        res_next.dest_index = 5'd0;
        res_next.dest_value = 64'd0;
        current_level_next  = current_level_reg;
        sstatus_next        = sstatus_reg;
        stvec_next          = stvec_reg;
        mstatus_next        = mstatus_reg;
        mepc_next           = mepc_reg;
        sepc_next           = sepc_reg;

        case (item_reg.op)
            pcsr_pkg::OP_WRITE:
            begin
                res_next.next_pc = item_reg.pc + 64'd4;
                if (item_reg.found)
                begin
                    if (!lvl_ok)
                    begin
                        kill = 1'b1;
                    end
                    else if ((item_reg.idx == pcsr_pkg::IDX_MVENDORID) &&
                             ((current_level_reg == pcsr_pkg::LVL_U) ||
                              (item_reg.src == 64'd0)))
                    begin
                        kill = 1'b1;
                    end
                    else
                    begin
                        csr_we = 1'b1;
                    end
                end
            end
            pcsr_pkg::OP_READ:
            begin
                res_next.next_pc = item_reg.pc + 64'd4;
                if (item_reg.found)
                begin
                    if (!lvl_ok)
                    begin
                        kill = 1'b1;
                    end
                    else if (item_reg.rd != 5'd0)
                    begin
                        res_next.write_back = 1'b1;
                        res_next.dest_index = item_reg.rd;
                        res_next.dest_value = csr_cur;
                    end
                end
            end
            pcsr_pkg::OP_ECALL:
            begin
                sepc_next          = item_reg.pc;
                res_next.next_pc   = stvec_reg;
                current_level_next = pcsr_pkg::LVL_S;
            end
            pcsr_pkg::OP_SRET:
            begin
                if (current_level_reg >= pcsr_pkg::LVL_S)
                begin
                    sstatus_next       = sret_status;
                    current_level_next = sstatus_reg[8] ? pcsr_pkg::LVL_S : pcsr_pkg::LVL_U;
                    res_next.next_pc   = sepc_reg;
                end
                else
                begin
                    kill = 1'b1;
                end
            end
            pcsr_pkg::OP_MRET:
            begin
                if (current_level_reg >= pcsr_pkg::LVL_M)
                begin
                    mstatus_next       = mret_status;
                    current_level_next = mret_level;
                    res_next.next_pc   = mepc_reg;
                end
                else
                begin
                    kill = 1'b1;
                end
            end
            pcsr_pkg::OP_NOP:
            begin
                kill = 1'b0;
            end
            default:
            begin
                kill = 1'b1;
            end
        endcase

        // A CSR write to one of the dedicated registers.
        if (csr_we)
        begin
            if (item_reg.idx == pcsr_pkg::IDX_SSTATUS)
            begin
                sstatus_next = item_reg.src;
            end
            if (item_reg.idx == pcsr_pkg::IDX_STVEC)
            begin
                stvec_next = item_reg.src;
            end
            if (item_reg.idx == pcsr_pkg::IDX_MSTATUS)
            begin
                mstatus_next = item_reg.src;
            end
            if (item_reg.idx == pcsr_pkg::IDX_MEPC)
            begin
                mepc_next = item_reg.src;
            end
            if (item_reg.idx == pcsr_pkg::IDX_SEPC)
            begin
                sepc_next = item_reg.src;
            end
        end

        res_next.killed    = kill;
        res_next.privilege = current_level_next;
    end

    assign mem_we = fire && csr_we && !special;

    always_comb
    begin
        valid_next = valid_reg;
        if (mem_we)
        begin
            valid_next[item_reg.idx] = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            valid_reg         <= '0;
            current_level_reg <= pcsr_pkg::LVL_M;
            sstatus_reg       <= 64'd0;
            stvec_reg         <= 64'd0;
            mstatus_reg       <= pcsr_pkg::MSTATUS_RESET;
            mepc_reg          <= 64'd0;
            sepc_reg          <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (fire && !kill)
            begin
                current_level_reg <= current_level_next;
                sstatus_reg       <= sstatus_next;
                stvec_reg         <= stvec_next;
                mstatus_reg       <= mstatus_next;
                mepc_reg          <= mepc_next;
                sepc_reg          <= sepc_next;
            end
        end
    end

    // Payload registers and the CSR memory.
    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            item_reg      <= head_item;
            mem_rdata_reg <= csr_mem[head_item.idx];
            rd_valid_reg  <= valid_reg[head_item.idx];
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            csr_mem[item_reg.idx] <= item_reg.src;
        end
    end

    `PCSR_ASSERT_NOW(a_kill_no_wb, clk, rst_n,
        out_valid_reg && res_reg.killed, !res_reg.write_back,
        "killed result carries a write-back")
    `PCSR_ASSERT_NOW(a_wb_not_x0, clk, rst_n,
        out_valid_reg && res_reg.write_back, res_reg.dest_index != 5'd0,
        "write-back targets x0")
    `PCSR_ASSERT_NOW(a_mem_we_exec, clk, rst_n,
        mem_we, (state_reg == ST_EXEC) && !kill,
        "CSR memory written outside a committed step")
    `PCSR_ASSERT_NEXT(a_kill_keeps_state, clk, rst_n,
        fire && kill,
        $stable(current_level_reg) && $stable(mstatus_reg) &&
        $stable(sstatus_reg) && $stable(sepc_reg),
        "killed step changed state")

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// Stand-alone bench for the privileged CSR emulation unit.
// An initial block builds the whole list of trapped instructions up front.
// A clocked driver offers them on the slave stream. At each accepted beat it
// runs a small behavioral predictor of the CSR bank and the privilege level
// and queues the result that the beat must produce. A clocked monitor takes
// result beats off the master stream and compares each field with the oldest
// queued prediction.
module testbench;

    // Clock, reset and the two stream groups.
    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             trap_valid = 1'b0;
    logic                             trap_ready;
    logic [pcsr_pkg::IN_TDATA_W-1:0]  trap_data = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    logic [pcsr_pkg::OUT_TDATA_W-1:0] result_data;

    // Opcode of a SYSTEM instruction; the block ignores it, but most words carry it.
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // CSR addresses that the stimulus aims at on purpose.
    localparam logic [11:0] A_USTATUS   = 12'h000;
    localparam logic [11:0] A_SSTATUS   = 12'h100;
    localparam logic [11:0] A_STVEC     = 12'h105;
    localparam logic [11:0] A_SEPC      = 12'h141;
    localparam logic [11:0] A_MVENDORID = 12'hF11;
    localparam logic [11:0] A_MSTATUS   = 12'h300;
    localparam logic [11:0] A_MEPC      = 12'h341;
    localparam logic [11:0] A_UNMAPPED  = 12'h7C0;
    localparam logic [11:0] A_WFI       = 12'h105;

    // Slots in the bank of CSRs that the predictor handles specially.
    localparam int SLOT_SSTATUS   = 8;
    localparam int SLOT_STVEC     = 12;
    localparam int SLOT_MVENDORID = 15;
    localparam int SLOT_MSTATUS   = 19;
    localparam int SLOT_MEPC      = 28;
    localparam int SLOT_SEPC      = 35;

    // Address and lowest privilege that may touch each slot.
    localparam logic [11:0] CSR_ADDRESS_MAP [pcsr_pkg::NUM_CSRS] = '{
        12'h000, 12'h004, 12'h005, 12'h040, 12'h041, 12'h042, 12'h043, 12'h044,
        12'h100, 12'h102, 12'h103, 12'h104, 12'h105, 12'h106, 12'h180,
        12'hF11, 12'hF12, 12'hF13, 12'hF14,
        12'h300, 12'h301, 12'h302, 12'h303, 12'h304, 12'h305, 12'h306, 12'h310,
        12'h340, 12'h341, 12'h342, 12'h343, 12'h344, 12'h34A, 12'h34B,
        12'h140, 12'h141, 12'h142, 12'h143, 12'h144
    };
    localparam logic [1:0] CSR_MIN_LEVEL [pcsr_pkg::NUM_CSRS] = '{
        pcsr_pkg::LVL_U, pcsr_pkg::LVL_U, pcsr_pkg::LVL_U, pcsr_pkg::LVL_U,
        pcsr_pkg::LVL_U, pcsr_pkg::LVL_U, pcsr_pkg::LVL_U, pcsr_pkg::LVL_U,
        pcsr_pkg::LVL_S, pcsr_pkg::LVL_S, pcsr_pkg::LVL_S, pcsr_pkg::LVL_S,
        pcsr_pkg::LVL_S, pcsr_pkg::LVL_S, pcsr_pkg::LVL_S,
        pcsr_pkg::LVL_S, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M,
        pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M,
        pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M,
        pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M,
        pcsr_pkg::LVL_M, pcsr_pkg::LVL_M, pcsr_pkg::LVL_M,
        pcsr_pkg::LVL_S, pcsr_pkg::LVL_S, pcsr_pkg::LVL_S, pcsr_pkg::LVL_S,
        pcsr_pkg::LVL_S
    };

    // The receiver holds off for this long once this many beats went in.
    localparam int HOLD_AFTER  = 100;
    localparam int HOLD_CYCLES = 80;
    // Beats built in this window are sent back to back so the block backs up.
    localparam int BURST_FIRST = 90;
    localparam int BURST_LAST  = 200;
    localparam int MAX_WAIT    = 17;

    // One trapped instruction as the driver offers it. gap is the number of
    // idle cycles before it; with drain set it is held back until every
    // predicted result has come out.
    typedef struct {
        logic [31:0] word;
        logic [63:0] pc;
        logic [63:0] rs1_value;
        int          gap;
        bit          drain;
    } trap_beat_t;

    trap_beat_t             trap_queue[$];
    pcsr_pkg::pcsr_result_t expected_results[$];

    // Predictor state: the guest's CSR bank and its current privilege level.
    logic [63:0] csr_bank [pcsr_pkg::NUM_CSRS];
    logic [1:0]  guest_level;

    int  beats_built = 0;
    int  beats_sent;
    int  results_seen;
    int  wait_cycles;
    int  stall_left;
    int  mismatches = 0;
    int  kill_count = 0;
    int  writeback_count = 0;
    int  ecall_count = 0;
    int  sret_count = 0;
    int  mret_count = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm;
    logic rx_hold = 1'b0;

    privileged_csr_emulation_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (trap_valid),
        .s_axis_tready (trap_ready),
        // instruction (32), pc (64), source_value (64), from bit 0 up.
        .s_axis_tdata  (trap_data),
        .m_axis_tvalid (result_valid),
        .m_axis_tready (result_ready),
        // killed (1), next_pc (64), write_back (1), dest_index (5),
        // dest_value (64), privilege (2), zero fill (7), from bit 0 up.
        .m_axis_tdata  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_guest();
        for (int i = 0; i < pcsr_pkg::NUM_CSRS; i++)
        begin
            csr_bank[i] = 64'd0;
        end
        csr_bank[SLOT_MVENDORID] = 64'hC5E536;
        csr_bank[SLOT_MSTATUS]   = 64'h1800;
        guest_level = pcsr_pkg::LVL_M;
    endfunction

    // Slot that holds the CSR at this address, or -1 when it is not mapped.
    function automatic int csr_slot(input logic [11:0] addr);
        int found;
        found = -1;
        for (int i = 0; i < pcsr_pkg::NUM_CSRS; i++)
        begin
            if (found < 0 && CSR_ADDRESS_MAP[i] == addr)
            begin
                found = i;
            end
        end
        return found;
    endfunction

    // Emulates one trapped instruction on the predictor state and returns the
    // result beat it must produce.
    function automatic pcsr_pkg::pcsr_result_t emulate_trap(input logic [31:0] word,
                                                            input logic [63:0] pc,
                                                            input logic [63:0] rs1_value);
        pcsr_pkg::pcsr_result_t r;
        logic [4:0]             rd;
        logic [2:0]             f3;
        logic [11:0]            addr;
        int                     slot;
        logic [63:0]            status;
        logic [1:0]             new_level;

        rd   = word[11:7];
        f3   = word[14:12];
        addr = word[31:20];
        slot = csr_slot(addr);
        r = '0;
        r.next_pc = pc;

        case (f3)
            pcsr_pkg::F3_CSRW:
            begin
                r.next_pc = pc + 64'd4;
                if (slot >= 0)
                begin
                    if (guest_level < CSR_MIN_LEVEL[slot])
                    begin
                        r.killed = 1'b1;
                    end
                    // The vendor id may never be cleared, nor touched from user mode.
                    else if (slot == SLOT_MVENDORID &&
                             (guest_level == pcsr_pkg::LVL_U || rs1_value == 64'd0))
                    begin
                        r.killed = 1'b1;
                    end
                    else
                    begin
                        csr_bank[slot] = rs1_value;
                    end
                end
            end
            pcsr_pkg::F3_CSRR:
            begin
                r.next_pc = pc + 64'd4;
                if (slot >= 0)
                begin
                    if (guest_level < CSR_MIN_LEVEL[slot])
                    begin
                        r.killed = 1'b1;
                    end
                    else if (rd != 5'd0)
                    begin
                        r.write_back = 1'b1;
                        r.dest_index = rd;
                        r.dest_value = csr_bank[slot];
                    end
                end
            end
            pcsr_pkg::F3_SYSTEM:
            begin
                if (addr == pcsr_pkg::ADDR_ECALL)
                begin
                    csr_bank[SLOT_SEPC] = pc;
                    r.next_pc = csr_bank[SLOT_STVEC];
                    guest_level = pcsr_pkg::LVL_S;
                    ecall_count++;
                end
                else if (addr == pcsr_pkg::ADDR_SRET)
                begin
                    if (guest_level == pcsr_pkg::LVL_U)
                    begin
                        r.killed = 1'b1;
                    end
                    else
                    begin
                        status = csr_bank[SLOT_SSTATUS];
                        new_level = status[8] ? pcsr_pkg::LVL_S : pcsr_pkg::LVL_U;
                        status[1] = status[5];
                        status[5] = 1'b1;
                        status[8] = 1'b0;
                        csr_bank[SLOT_SSTATUS] = status;
                        r.next_pc = csr_bank[SLOT_SEPC];
                        guest_level = new_level;
                        sret_count++;
                    end
                end
                else if (addr == pcsr_pkg::ADDR_MRET)
                begin
                    if (guest_level != pcsr_pkg::LVL_M)
                    begin
                        r.killed = 1'b1;
                    end
                    else
                    begin
                        status = csr_bank[SLOT_MSTATUS];
                        // The reserved MPP encoding returns to machine mode too.
                        new_level = status[12] ? pcsr_pkg::LVL_M : {1'b0, status[11]};
                        status[3] = status[7];
                        status[7] = 1'b1;
                        status[12:11] = 2'b00;
                        if (new_level != pcsr_pkg::LVL_M)
                        begin
                            status[17] = 1'b0;
                        end
                        csr_bank[SLOT_MSTATUS] = status;
                        r.next_pc = csr_bank[SLOT_MEPC];
                        guest_level = new_level;
                        mret_count++;
                    end
                end
            end
            default:
            begin
                r.killed = 1'b1;
            end
        endcase

        r.privilege = guest_level;
        if (r.killed)
        begin
            kill_count++;
        end
        if (r.write_back)
        begin
            writeback_count++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Register values lean toward all zeros and all ones now and then.
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = 64'd0;
            1: v = '1;
            default: v = rand64();
        endcase
        return v;
    endfunction

    function automatic logic [4:0] rand_rd();
        return ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom);
    endfunction

    // Mostly mapped CSRs, with extra weight on the ones that change control
    // flow, and some fully random addresses that are usually unmapped.
    function automatic logic [11:0] rand_addr();
        logic [11:0] a;
        case ($urandom_range(0, 9))
            0:       a = 12'($urandom);
            1:       a = A_SSTATUS;
            2:       a = A_MSTATUS;
            3:       a = ($urandom_range(0, 1) == 0) ? A_SEPC : A_MEPC;
            4:       a = ($urandom_range(0, 1) == 0) ? A_STVEC : A_MVENDORID;
            default: a = CSR_ADDRESS_MAP[$urandom_range(0, pcsr_pkg::NUM_CSRS - 1)];
        endcase
        return a;
    endfunction

    // A system word around the given fields; rs1 and the opcode are filler the
    // block must ignore, so they are random and the opcode is sometimes odd.
    function automatic logic [31:0] sys_word(input logic [11:0] addr,
                                             input logic [2:0]  f3,
                                             input logic [4:0]  rd);
        logic [6:0] opcode;
        opcode = ($urandom_range(0, 7) == 0) ? 7'($urandom) : OPC_SYSTEM;
        return {addr, 5'($urandom), f3, rd, opcode};
    endfunction

    // Funct3 zero with an address that is none of ecall, sret and mret.
    function automatic logic [11:0] other_sys_addr();
        logic [11:0] a;
        a = 12'($urandom);
        if (a == pcsr_pkg::ADDR_ECALL || a == pcsr_pkg::ADDR_SRET ||
            a == pcsr_pkg::ADDR_MRET)
        begin
            a = A_WFI;
        end
        return a;
    endfunction

    // Queues one beat. The sender alternates between calm stretches with no
    // idle cycles and busy stretches with random gaps.
    task automatic add_beat(input logic [31:0] word, input logic [63:0] pc,
                            input logic [63:0] value, input bit drain);
        trap_beat_t b;
        if ($urandom_range(0, 24) == 0)
        begin
            tx_calm = !tx_calm;
        end
        b.word      = word;
        b.pc        = pc;
        b.rs1_value = value;
        b.drain     = drain;
        if (beats_built >= BURST_FIRST && beats_built <= BURST_LAST)
        begin
            b.gap = 0;
        end
        else
        begin
            b.gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
        trap_queue.push_back(b);
        beats_built++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued beats and predicts each one as it is accepted.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        logic                            next_valid;
        logic [pcsr_pkg::IN_TDATA_W-1:0] next_data;
        trap_beat_t                      head;
        if (!rst_n)
        begin
            trap_valid  <= 1'b0;
            trap_data   <= '0;
            beats_sent  <= 0;
            wait_cycles <= 0;
            reset_guest();
        end
        else
        begin
            next_valid = trap_valid;
            next_data  = trap_data;
            if (trap_valid && trap_ready)
            begin
                expected_results.push_back(emulate_trap(trap_data[31:0], trap_data[95:32],
                                                        trap_data[159:96]));
                beats_sent <= beats_sent + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && trap_queue.size() != 0)
            begin
                head = trap_queue[0];
                if (wait_cycles < head.gap)
                begin
                    wait_cycles <= wait_cycles + 1;
                end
                else if (!(head.drain && expected_results.size() != 0))
                begin
                    void'(trap_queue.pop_front());
                    next_valid = 1'b1;
                    next_data  = {head.rs1_value, head.pc, head.word};
                    wait_cycles <= 0;
                end
            end
            trap_valid <= next_valid;
            trap_data  <= next_data;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every result beat against the oldest prediction.
    // ------------------------------------------------------------------

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int                     stall;
        pcsr_pkg::pcsr_result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
            results_seen <= 0;
            rx_calm      <= 1'b1;
        end
        else
        begin
            stall = stall_left;
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, result_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("killed", want.killed, result_data[0]);
                    check_field("next_pc", want.next_pc, result_data[64:1]);
                    check_field("write_back", want.write_back, result_data[65]);
                    check_field("dest_index", want.dest_index, result_data[70:66]);
                    check_field("dest_value", want.dest_value, result_data[134:71]);
                    check_field("privilege", want.privilege, result_data[136:135]);
                end
                if ($urandom_range(0, 29) == 0)
                begin
                    rx_calm <= !rx_calm;
                end
                stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall != 0)
            begin
                stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= !rx_hold;
            end
            stall_left <= stall;
        end
    end

    // Long receiver hold-off while the sender keeps pushing: the internal queue
    // and the output register fill up and the block must drop s_axis_tready.
    initial
    begin
        while (beats_sent < HOLD_AFTER)
        begin
            @(posedge clk);
        end
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        logic [63:0] v;
        int          pick;

        // Directed, machine mode: reset values, read into x0, vendor id rules,
        // mret through the reserved MPP encoding, illegal funct3, other system
        // words, unmapped CSRs and the pc wrapping past the top.
        add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRR, 5'd5), 64'h1000, 64'd0, 1'b0);
        add_beat(sys_word(A_MSTATUS, pcsr_pkg::F3_CSRR, 5'd31), 64'h1004, '1, 1'b0);
        add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRR, 5'd0), 64'h1008, 64'd0, 1'b0);
        add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRW, 5'd0), 64'h100C, 64'd0, 1'b0);
        add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRW, 5'd0), 64'h1010, '1, 1'b0);
        add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRR, 5'd1), 64'h1014, 64'd0, 1'b0);
        add_beat(sys_word(A_MSTATUS, pcsr_pkg::F3_CSRW, 5'd0), 64'h1018, 64'h0002_1080,
                 1'b0);
        add_beat(sys_word(A_MEPC, pcsr_pkg::F3_CSRW, 5'd0), 64'h101C,
                 64'hFFFF_FFFF_FFFF_FFFC, 1'b0);
        add_beat(sys_word(pcsr_pkg::ADDR_MRET, pcsr_pkg::F3_SYSTEM, 5'd0), 64'h1020, 64'd0,
                 1'b0);
        add_beat(sys_word(A_MSTATUS, pcsr_pkg::F3_CSRR, 5'd7), 64'd0, 64'd0, 1'b0);
        add_beat(sys_word(A_SSTATUS, 3'd3, 5'd2), 64'h2000, 64'd0, 1'b0);
        add_beat('1, 64'h2004, '1, 1'b0);
        add_beat(sys_word(A_WFI, pcsr_pkg::F3_SYSTEM, 5'd9), 64'h2008, 64'd0, 1'b0);
        add_beat(sys_word(A_UNMAPPED, pcsr_pkg::F3_CSRR, 5'd3), '1, 64'd0, 1'b0);
        add_beat(sys_word(12'hFFF, pcsr_pkg::F3_CSRW, 5'd0), 64'h200C, '1, 1'b0);
        add_beat(sys_word(A_STVEC, pcsr_pkg::F3_CSRW, 5'd0), 64'h2010,
                 64'h8000_0000_0000_1000, 1'b0);
        add_beat(sys_word(A_USTATUS, pcsr_pkg::F3_CSRR, 5'd31), 64'h2014, 64'd0, 1'b0);

        // Random, machine mode. Leaving machine mode is one way, so mret only
        // follows an mstatus write that keeps MPP at machine level.
        for (int n = 0; n < 185; n++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 6)
            begin
                add_beat(sys_word(rand_addr(), pcsr_pkg::F3_CSRW, rand_rd()), rand64(),
                         rand_value(), 1'b0);
            end
            else if (pick < 12)
            begin
                add_beat(sys_word(rand_addr(), pcsr_pkg::F3_CSRR, rand_rd()), rand64(),
                         rand_value(), 1'b0);
            end
            else if (pick == 12)
            begin
                v = rand64();
                v[12] = 1'b1;
                add_beat(sys_word(A_MSTATUS, pcsr_pkg::F3_CSRW, rand_rd()), rand64(), v,
                         1'b0);
                add_beat(sys_word(pcsr_pkg::ADDR_MRET, pcsr_pkg::F3_SYSTEM, rand_rd()),
                         rand64(), rand64(), 1'b0);
            end
            else if (pick == 13)
            begin
                add_beat(sys_word(rand_addr(), 3'($urandom_range(3, 7)), rand_rd()), rand64(),
                         rand64(), 1'b0);
            end
            else if (pick == 14)
            begin
                add_beat(sys_word(other_sys_addr(), pcsr_pkg::F3_SYSTEM, rand_rd()),
                         rand64(), rand64(), 1'b0);
            end
            else
            begin
                v = ($urandom_range(0, 1) == 0) ? 64'd0 : rand64();
                add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRW, rand_rd()), rand64(), v,
                         1'b0);
            end
        end

        // Directed drop to supervisor mode through MPP = 1 with MPRV set, after
        // the sender waits for every result so far. Then ecall with the top pc,
        // sret both ways, and the checks that only apply below machine mode.
        add_beat(sys_word(A_MSTATUS, pcsr_pkg::F3_CSRW, 5'd0), 64'h3000, 64'h0002_0880,
                 1'b1);
        add_beat(sys_word(pcsr_pkg::ADDR_MRET, pcsr_pkg::F3_SYSTEM, 5'd0), 64'h3004, 64'd0,
                 1'b0);
        add_beat(sys_word(pcsr_pkg::ADDR_ECALL, pcsr_pkg::F3_SYSTEM, 5'd0), '1, 64'd0, 1'b0);
        add_beat(sys_word(A_SSTATUS, pcsr_pkg::F3_CSRW, 5'd0), 64'h3008, 64'h120, 1'b0);
        add_beat(sys_word(pcsr_pkg::ADDR_SRET, pcsr_pkg::F3_SYSTEM, 5'd0), 64'h300C, 64'd0,
                 1'b0);
        add_beat(sys_word(A_SSTATUS, pcsr_pkg::F3_CSRW, 5'd0), 64'h3010, 64'd0, 1'b0);
        add_beat(sys_word(pcsr_pkg::ADDR_SRET, pcsr_pkg::F3_SYSTEM, 5'd0), 64'h3014, 64'd0,
                 1'b0);
        add_beat(sys_word(pcsr_pkg::ADDR_SRET, pcsr_pkg::F3_SYSTEM, 5'd0), 64'h3018, 64'd0,
                 1'b0);
        add_beat(sys_word(A_MVENDORID, pcsr_pkg::F3_CSRW, 5'd0), 64'h301C, 64'h55, 1'b0);
        add_beat(sys_word(pcsr_pkg::ADDR_MRET, pcsr_pkg::F3_SYSTEM, 5'd0), 64'h3020, 64'd0,
                 1'b0);

        // Random, supervisor and user mode: ecall and sret move between the two.
        for (int n = 0; n < 205; n++)
        begin
            pick = $urandom_range(0, 16);
            if (pick < 5)
            begin
                add_beat(sys_word(rand_addr(), pcsr_pkg::F3_CSRW, rand_rd()), rand64(),
                         rand_value(), n == 100);
            end
            else if (pick < 10)
            begin
                add_beat(sys_word(rand_addr(), pcsr_pkg::F3_CSRR, rand_rd()), rand64(),
                         rand_value(), n == 100);
            end
            else if (pick < 12)
            begin
                add_beat(sys_word(pcsr_pkg::ADDR_ECALL, pcsr_pkg::F3_SYSTEM, rand_rd()),
                         rand64(), rand64(), n == 100);
            end
            else if (pick < 14)
            begin
                add_beat(sys_word(A_SSTATUS, pcsr_pkg::F3_CSRW, rand_rd()), rand64(),
                         rand_value(), n == 100);
                add_beat(sys_word(pcsr_pkg::ADDR_SRET, pcsr_pkg::F3_SYSTEM, rand_rd()),
                         rand64(), rand64(), 1'b0);
            end
            else if (pick == 14)
            begin
                add_beat(sys_word(pcsr_pkg::ADDR_MRET, pcsr_pkg::F3_SYSTEM, rand_rd()),
                         rand64(), rand64(), n == 100);
            end
            else if (pick == 15)
            begin
                add_beat(sys_word(rand_addr(), 3'($urandom_range(3, 7)), rand_rd()), rand64(),
                         rand64(), n == 100);
            end
            else
            begin
                add_beat(sys_word(other_sys_addr(), pcsr_pkg::F3_SYSTEM, rand_rd()),
                         rand64(), rand64(), n == 100);
            end
        end

        // Let everything drain, then allow a few cycles for stray beats.
        while (trap_queue.size() != 0 || trap_valid)
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Ran %0d trapped instructions through both streams, %0d results checked.",
                 beats_sent, results_seen);
        $display("Saw %0d kills, %0d write-backs, %0d ecall, %0d sret and %0d mret taken.",
                 kill_count, writeback_count, ecall_count, sret_count, mret_count);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("[privileged_csr_emulation_unit] OK");
        end
        else
        begin
            $display("[privileged_csr_emulation_unit] ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("%0t: timeout with %0d results still expected", $time,
                 expected_results.size());
        $display("[privileged_csr_emulation_unit] ERROR");
        $finish;
    end

endmodule

>>> privileged_csr_emulation_unit.f
+incdir+sv
sv/pcsr_pkg.sv
sv/pcsr_front.sv
sv/pcsr_queue.sv
sv/pcsr_back.sv
sv/privileged_csr_emulation_unit.sv
tb/sv/testbench.sv
